[rtl/plt_pkg.sv]
// plt_pkg: shared types, widths and codes for the positional list table.
// Used by the channel interfaces, the controller and the top level.
package plt_pkg;

    localparam int MAX_ENTRIES_DEF = 32;
    localparam int CMD_W = 2;
    localparam int POS_W = 6;
    localparam int VAL_W = 32;
    localparam int ST_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_LOCATE = 2'd2
    } t_cmd_code;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_DRAIN,
        S_INS_PUT,
        S_DEL_SHIFT,
        S_DEL_DRAIN,
        S_DEL_CLEAR,
        S_LOC_SCAN,
        S_LOC_DRAIN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic                    valid;
        t_status                 status;
        logic signed [VAL_W-1:0] removed_value;
        logic [POS_W-1:0]        found_position;
        logic [POS_W-1:0]        list_length;
        logic                    is_empty;
    } t_resp;

endpackage

[rtl/plt_if.sv]
// plt_if: valid/ready channel interfaces for command and result items.
// Depends on plt_pkg for field widths.
interface plt_in_if;
    logic                            valid;
    logic                            ready;
    logic [plt_pkg::CMD_W-1:0]       cmd;
    logic [plt_pkg::POS_W-1:0]       position;
    logic signed [plt_pkg::VAL_W-1:0] value;

    modport source (output valid, output cmd, output position, output value, input ready);
    modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface plt_out_if;
    logic                             valid;
    logic                             ready;
    logic [plt_pkg::ST_W-1:0]         status;
    logic signed [plt_pkg::VAL_W-1:0] removed_value;
    logic [plt_pkg::POS_W-1:0]        found_position;
    logic [plt_pkg::POS_W-1:0]        list_length;
    logic                             is_empty;

    modport source (output valid, output status, output removed_value,
                    output found_position, output list_length, output is_empty,
                    input ready);
    modport sink   (input valid, input status, input removed_value,
                    input found_position, input list_length, input is_empty,
                    output ready);
endinterface

[rtl/positional_list_table_top.sv]
// positional_list_table_top: ordered list of signed words with insert,
// delete and locate commands. Depends on plt_pkg, plt_if, plt_mem, plt_ctrl.

// The block holds an ordered list of up to MAX_ENTRIES signed 32-bit words
// in a single-port-write, registered-read store, plus a length count. One
// command item is taken at a time; i_in.ready is high only while the
// sequencer is idle. After a command is accepted, the store is walked one
// word per cycle: insert at position p moves the words from p to the tail
// up (an append skips the sweep), delete at p moves the words above p down,
// locate scans from the head and stops at the first match, and rejected
// or unused commands go straight to the result. Finished results sit in an
// output register, so a stalled sink only holds the block once a second
// result is ready. The store needs no clearing pass after reset: words at
// or above the length are never read before they are written.
module positional_list_table_top #(
    parameter int MAX_ENTRIES = plt_pkg::MAX_ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    plt_in_if.sink    i_in,
    plt_out_if.source o_out
);

    localparam int AW = $clog2(MAX_ENTRIES);

    plt_pkg::t_cmd             cmd;
    plt_pkg::t_resp            resp;
    logic                      resp_take;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [plt_pkg::VAL_W-1:0] wr_data;
    logic                      rd_en;
    logic [AW-1:0]             rd_addr;
    logic [plt_pkg::VAL_W-1:0] rd_data;

    // result register
    logic                             r_out_valid, n_out_valid;
    logic [plt_pkg::ST_W-1:0]         r_status;
    logic signed [plt_pkg::VAL_W-1:0] r_removed;
    logic [plt_pkg::POS_W-1:0]        r_found;
    logic [plt_pkg::POS_W-1:0]        r_length;
    logic                             r_empty;

    assign cmd.cmd      = i_in.cmd;
    assign cmd.position = i_in.position;
    assign cmd.value    = i_in.value;

    plt_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_in.valid),
        .i_cmd       (cmd),
        .o_cmd_ready (i_in.ready),
        .o_resp      (resp),
        .i_resp_take (resp_take),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data)
    );

    plt_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // load a result when the register is empty or being drained this cycle
    assign resp_take = resp.valid && (!r_out_valid || o_out.ready);

    always_comb begin
        n_out_valid = r_out_valid;
        if (resp_take) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (resp_take) begin
            r_status  <= resp.status;
            r_removed <= resp.removed_value;
            r_found   <= resp.found_position;
            r_length  <= resp.list_length;
            r_empty   <= resp.is_empty;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.removed_value  = r_removed;
    assign o_out.found_position = r_found;
    assign o_out.list_length    = r_length;
    assign o_out.is_empty       = r_empty;

endmodule

[rtl/plt_mem.sv]
// plt_mem: entry store, one write port and one registered read port.
// Depends on plt_pkg for the word width.
module plt_mem #(
    parameter int DEPTH = plt_pkg::MAX_ENTRIES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [plt_pkg::VAL_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [plt_pkg::VAL_W-1:0] o_rd_data
);

    logic [plt_pkg::VAL_W-1:0] r_mem [DEPTH];
    logic [plt_pkg::VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/plt_ctrl.sv]
// plt_ctrl: command sequencer; walks the entry store one word per cycle
// for shifts and searches. Depends on plt_pkg; drives plt_mem ports.
module plt_ctrl #(
    parameter int MAX_ENTRIES = plt_pkg::MAX_ENTRIES_DEF,
    parameter int AW          = $clog2(MAX_ENTRIES)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  plt_pkg::t_cmd             i_cmd,
    output logic                      o_cmd_ready,
    output plt_pkg::t_resp            o_resp,
    input  logic                      i_resp_take,
    output logic                      o_wr_en,
    output logic [AW-1:0]             o_wr_addr,
    output logic [plt_pkg::VAL_W-1:0] o_wr_data,
    output logic                      o_rd_en,
    output logic [AW-1:0]             o_rd_addr,
    input  logic [plt_pkg::VAL_W-1:0] i_rd_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = ((CW > plt_pkg::POS_W) ? CW : plt_pkg::POS_W) + 1;

    plt_pkg::t_state              r_state, n_state;
    logic [CW-1:0]                r_count, n_count;
    logic [AW-1:0]                r_ptr, n_ptr;
    logic [AW-1:0]                r_pos0, n_pos0;
    logic [AW-1:0]                r_waddr, n_waddr;
    logic                         r_pend, n_pend;
    logic                         r_pfirst, n_pfirst;
    logic                         r_first, n_first;
    logic [plt_pkg::VAL_W-1:0]    r_val, n_val;
    plt_pkg::t_status             r_status, n_status;
    logic [plt_pkg::VAL_W-1:0]    r_removed, n_removed;
    logic [plt_pkg::POS_W-1:0]    r_found, n_found;

    logic [PW-1:0]                pos_x;
    logic [PW-1:0]                cnt_x;
    logic [PW-1:0]                cnt_len;
    logic [PW-1:0]                hit_pos;
    logic [AW-1:0]                last_idx;
    logic                         hit;

    assign pos_x    = PW'(i_cmd.position);
    assign cnt_x    = PW'(r_count);
    assign cnt_len  = PW'(r_count);
    assign last_idx = AW'(cnt_x - PW'(1));
    assign hit_pos  = PW'(r_waddr) + PW'(1);
    // shared comparator: pending read word against the search value
    assign hit      = r_pend && (i_rd_data == r_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plt_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_pos0    <= n_pos0;
        r_waddr   <= n_waddr;
        r_pfirst  <= n_pfirst;
        r_first   <= n_first;
        r_val     <= n_val;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_found   <= n_found;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_pos0    = r_pos0;
        n_waddr   = r_waddr;
        n_pend    = 1'b0;
        n_pfirst  = r_pfirst;
        n_first   = r_first;
        n_val     = r_val;
        n_status  = r_status;
        n_removed = r_removed;
        n_found   = r_found;
        o_cmd_ready = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_waddr;
        o_wr_data = i_rd_data;
        o_rd_en   = 1'b0;
        o_rd_addr = r_ptr;

        case (r_state)
            plt_pkg::S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_val     = i_cmd.value;
                    n_removed = '0;
                    n_found   = '0;
                    n_status  = plt_pkg::ST_OK;
                    n_first   = 1'b1;
                    n_state   = plt_pkg::S_RESP;
                    case (plt_pkg::t_cmd_code'(i_cmd.cmd))
                        plt_pkg::CMD_INSERT: begin
                            n_pos0 = AW'(pos_x - PW'(1));
                            n_ptr  = last_idx;
                            if (pos_x == '0 || pos_x > cnt_x + PW'(1)) begin
                                n_status = plt_pkg::ST_BAD_POS;
                            end else if (r_count == CW'(MAX_ENTRIES)) begin
                                n_status = plt_pkg::ST_FULL;
                            end else if (pos_x == cnt_x + PW'(1)) begin
                                n_state = plt_pkg::S_INS_PUT;
                            end else begin
                                n_state = plt_pkg::S_INS_SHIFT;
                            end
                        end
                        plt_pkg::CMD_DELETE: begin
                            n_ptr = AW'(pos_x - PW'(1));
                            if (pos_x == '0 || pos_x > cnt_x) begin
                                n_status = plt_pkg::ST_BAD_POS;
                            end else begin
                                n_state = plt_pkg::S_DEL_SHIFT;
                            end
                        end
                        plt_pkg::CMD_LOCATE: begin
                            n_ptr = '0;
                            if (r_count == '0) begin
                                n_status = plt_pkg::ST_NOT_FOUND;
                            end else begin
                                n_state = plt_pkg::S_LOC_SCAN;
                            end
                        end
                        default: begin
                            n_status = plt_pkg::ST_OK;
                        end
                    endcase
                end
            end

            // move entries up: read k-1, write it to k next cycle
            plt_pkg::S_INS_SHIFT: begin
                o_wr_en = r_pend;
                o_rd_en = 1'b1;
                n_pend  = 1'b1;
                n_waddr = r_ptr + AW'(1);
                if (r_ptr == r_pos0) begin
                    n_state = plt_pkg::S_INS_DRAIN;
                end else begin
                    n_ptr = r_ptr - AW'(1);
                end
            end

            plt_pkg::S_INS_DRAIN: begin
                o_wr_en = r_pend;
                n_state = plt_pkg::S_INS_PUT;
            end

            plt_pkg::S_INS_PUT: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_pos0;
                o_wr_data = r_val;
                n_count   = r_count + CW'(1);
                n_state   = plt_pkg::S_RESP;
            end

            // move entries down; first word read is the one removed
            plt_pkg::S_DEL_SHIFT: begin
                if (r_pend) begin
                    if (r_pfirst) begin
                        n_removed = i_rd_data;
                    end else begin
                        o_wr_en = 1'b1;
                    end
                end
                o_rd_en  = 1'b1;
                n_pend   = 1'b1;
                n_pfirst = r_first;
                n_first  = 1'b0;
                n_waddr  = r_ptr - AW'(1);
                if (r_ptr == last_idx) begin
                    n_state = plt_pkg::S_DEL_DRAIN;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end

            plt_pkg::S_DEL_DRAIN: begin
                if (r_pend) begin
                    if (r_pfirst) begin
                        n_removed = i_rd_data;
                    end else begin
                        o_wr_en = 1'b1;
                    end
                end
                n_state = plt_pkg::S_DEL_CLEAR;
            end

            plt_pkg::S_DEL_CLEAR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = last_idx;
                o_wr_data = '0;
                n_count   = r_count - CW'(1);
                n_state   = plt_pkg::S_RESP;
            end

            plt_pkg::S_LOC_SCAN: begin
                if (hit) begin
                    n_found  = hit_pos[plt_pkg::POS_W-1:0];
                    n_status = plt_pkg::ST_OK;
                    n_state  = plt_pkg::S_RESP;
                end else begin
                    o_rd_en = 1'b1;
                    n_pend  = 1'b1;
                    n_waddr = r_ptr;
                    if (r_ptr == last_idx) begin
                        n_state = plt_pkg::S_LOC_DRAIN;
                    end else begin
                        n_ptr = r_ptr + AW'(1);
                    end
                end
            end

            plt_pkg::S_LOC_DRAIN: begin
                if (hit) begin
                    n_found  = hit_pos[plt_pkg::POS_W-1:0];
                    n_status = plt_pkg::ST_OK;
                end else begin
                    n_status = plt_pkg::ST_NOT_FOUND;
                end
                n_state = plt_pkg::S_RESP;
            end

            plt_pkg::S_RESP: begin
                if (i_resp_take) begin
                    n_state = plt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = plt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_resp.valid          = (r_state == plt_pkg::S_RESP);
        o_resp.status         = r_status;
        o_resp.removed_value  = r_removed;
        o_resp.found_position = r_found;
        o_resp.list_length    = cnt_len[plt_pkg::POS_W-1:0];
        o_resp.is_empty       = (r_count == '0);
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1) || r_count == $past(r_count) - CW'(1)))
        else $error("entry count moved by more than one");

    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (r_state != plt_pkg::S_IDLE && r_state != plt_pkg::S_RESP))
        else $error("store written outside a command");

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> !r_pend)
        else $error("read still pending while idle");

endmodule

[verif/tb_positional_list_table_top.sv]
// tb_positional_list_table_top: self-checking bench for the positional list table.
// Predicts each command's result from its own copy of the list and compares
// every returned item. Depends on plt_pkg, plt_if and the positional_list_table_top RTL.
module tb_positional_list_table_top;
    import plt_pkg::*;

    // Code 3 has no operation behind it; the block must answer ok and change nothing.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    localparam int LIST_DEPTH       = MAX_ENTRIES_DEF;
    localparam int PHASE_CMDS       = 440;   // four random phases, ~1750 items in all
    localparam int HOLD_CYCLES      = 300;   // long result-side hold in the first random phase
    localparam int END_DRAIN_CYCLES = 80;    // longer than the worst command time, with margin
    // Longest correct stretch with no handshake on either side is the forced
    // hold plus one command, plus random stalls. Take it many times over.
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int MAX_PRINTS       = 100;

    typedef enum {FILL_UP, DRAIN_DOWN, CHURN} t_fill_mode;

    typedef struct {
        t_status                 status;
        logic signed [VAL_W-1:0] removed_value;
        logic [POS_W-1:0]        found_position;
        logic [POS_W-1:0]        list_length;
        logic                    is_empty;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    plt_in_if  in_ch ();
    plt_out_if out_ch ();

    positional_list_table_top #(
        .MAX_ENTRIES(LIST_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // Predicted list contents and length, advanced when a command is accepted.
    logic signed [VAL_W-1:0] list_words [LIST_DEPTH] = '{default: '0};
    int                      list_len = 0;

    // Length as the stimulus side plans it, so positions can be aimed at valid slots.
    int plan_len = 0;

    t_cmd         cmd_backlog[$];      // commands not yet offered
    t_list_result result_forecast[$];  // predicted results, oldest first
    t_cmd         offered_cmd;         // command currently on the input channel

    int cmds_queued   = 0;
    int cmds_taken    = 0;
    int fail_count    = 0;
    int send_idle_pct = 0;
    int sink_stall_pct = 0;
    int sink_hold_left = 0;
    int quiet_cycles  = 0;

    // Values that recur often, so locates hit and duplicates appear.
    logic signed [VAL_W-1:0] value_pool [8] = '{
        32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
        32'sh0000_0001, 32'sh5A5A_A5A5, 32'shA5A5_5A5A, 32'sh0000_0100
    };

    // ------------------------------------------------------------------
    // Prediction: apply one accepted command to the list copy.
    // ------------------------------------------------------------------
    function automatic t_list_result apply_list_cmd(input t_cmd c);
        t_list_result r;
        int           at;
        int           k;
        at               = int'(c.position);
        r.status         = ST_OK;
        r.removed_value  = '0;
        r.found_position = '0;
        case (c.cmd)
            CMD_INSERT: begin
                // position is checked before fullness
                if (at == 0 || at > list_len + 1) begin
                    r.status = ST_BAD_POS;
                end else if (list_len >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    for (k = list_len; k >= at; k--)
                        list_words[k] = list_words[k-1];
                    list_words[at-1] = c.value;
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (at == 0 || at > list_len) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.removed_value = list_words[at-1];
                    for (k = at; k < list_len; k++)
                        list_words[k-1] = list_words[k];
                    list_words[list_len-1] = '0;
                    list_len--;
                end
            end
            CMD_LOCATE: begin
                r.status = ST_NOT_FOUND;
                for (k = 0; k < list_len; k++) begin
                    if (list_words[k] == c.value) begin
                        r.found_position = POS_W'(k + 1);
                        r.status         = ST_OK;
                        break;
                    end
                end
            end
            default: ;  // unused code: nothing changes
        endcase
        r.list_length = POS_W'(list_len);
        r.is_empty    = (list_len == 0);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cmd(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                            input logic signed [VAL_W-1:0] val);
        t_cmd c;
        c.cmd      = op;
        c.position = pos;
        c.value    = val;
        if (op == CMD_INSERT && pos != 0 && pos <= plan_len + 1 && plan_len < LIST_DEPTH)
            plan_len++;
        else if (op == CMD_DELETE && pos != 0 && pos <= plan_len)
            plan_len--;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        if ($urandom_range(1) == 0)
            return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    // Mostly well-formed commands aimed at valid positions, in stretches that
    // grow the list to full, shrink it to empty, or churn around the middle.
    task automatic queue_random_cmds(input int count);
        t_fill_mode              mode;
        int                      ins_w;
        int                      del_w;
        int                      roll;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        mode = CHURN;
        for (int i = 0; i < count; i++) begin
            if (i % 48 == 0)
                mode = t_fill_mode'($urandom_range(2));
            case (mode)
                FILL_UP:    begin ins_w = 80; del_w = 10; end
                DRAIN_DOWN: begin ins_w = 15; del_w = 70; end
                default:    begin ins_w = 40; del_w = 35; end
            endcase
            pos  = POS_W'($urandom_range(63));
            val  = pick_value();
            roll = $urandom_range(99);
            if (roll < 5) begin
                // noise: any code, any position, any value
                push_cmd(CMD_W'($urandom_range(3)), pos, $urandom);
            end else begin
                roll = $urandom_range(99);
                if (roll < ins_w) begin
                    if ($urandom_range(9) != 0)
                        pos = POS_W'($urandom_range(plan_len + 1, 1));
                    push_cmd(CMD_INSERT, pos, val);
                end else if (roll < ins_w + del_w) begin
                    if (plan_len > 0 && $urandom_range(9) != 0)
                        pos = POS_W'($urandom_range(plan_len, 1));
                    push_cmd(CMD_DELETE, pos, val);
                end else begin
                    push_cmd(CMD_LOCATE, pos, val);
                end
            end
        end
    endtask

    // Sender holds until everything offered is taken and every result is back.
    task automatic wait_all_done();
        while (cmds_taken != cmds_queued || result_forecast.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        queue_random_cmds(count);
        wait_all_done();
    endtask

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Clock, with every block input at a known level from time zero
    // ------------------------------------------------------------------
    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.cmd       = '0;
        in_ch.position  = '0;
        in_ch.value     = '0;
        out_ch.ready    = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Single synchronous reset at the start of the run.
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Driver: offers backlog items; the prediction is taken on acceptance.
    // valid and payload get exactly one update per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                result_forecast.push_back(apply_list_cmd(offered_cmd));
                cmds_taken++;
            end
            // payload stays put while an item waits for ready
            if (!in_ch.valid || in_ch.ready) begin
                if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_cmd     = cmd_backlog.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.cmd      <= offered_cmd.cmd;
                    in_ch.position <= offered_cmd.position;
                    in_ch.value    <= offered_cmd.value;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each returned item against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (result_forecast.size() == 0) begin
                    report_mismatch("result with none pending", VAL_W'(out_ch.status), '0);
                end else begin
                    want = result_forecast.pop_front();
                    if (out_ch.status !== want.status)
                        report_mismatch("status", VAL_W'(out_ch.status), VAL_W'(want.status));
                    if (out_ch.removed_value !== want.removed_value)
                        report_mismatch("removed_value", out_ch.removed_value,
                                        want.removed_value);
                    if (out_ch.found_position !== want.found_position)
                        report_mismatch("found_position", VAL_W'(out_ch.found_position),
                                        VAL_W'(want.found_position));
                    if (out_ch.list_length !== want.list_length)
                        report_mismatch("list_length", VAL_W'(out_ch.list_length),
                                        VAL_W'(want.list_length));
                    if (out_ch.is_empty !== want.is_empty)
                        report_mismatch("is_empty", VAL_W'(out_ch.is_empty),
                                        VAL_W'(want.is_empty));
                end
            end
            out_ch.ready <= (sink_hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Long hold on the result side, counted down here; the block backs up
    // into its output register and then drops input ready.
    always @(posedge i_clk) begin
        if (sink_hold_left > 0)
            sink_hold_left <= sink_hold_left - 1;
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no progress for %0d cycles, %0d results outstanding",
                         $time, WATCHDOG_LIMIT, result_forecast.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence. Backlog is filled on falling edges, clear of the driver.
    // ------------------------------------------------------------------
    initial begin
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        // Directed part, no idling: empty-list cases, bad positions on both
        // sides, extremes of the value, insert at head/middle/tail, first-match
        // locate with duplicates, the unused code, and deletes down to empty.
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        push_cmd(CMD_LOCATE, 6'd0,  32'sh0000_0000);   // miss on empty list
        push_cmd(CMD_DELETE, 6'd1,  32'sh0000_0000);   // nothing to delete
        push_cmd(CMD_INSERT, 6'd0,  32'sh0000_0007);   // position zero
        push_cmd(CMD_INSERT, 6'd2,  32'sh0000_0007);   // past length + 1
        push_cmd(CMD_INSERT, 6'd1,  32'sh8000_0000);
        push_cmd(CMD_INSERT, 6'd2,  32'sh7FFF_FFFF);   // append
        push_cmd(CMD_INSERT, 6'd1,  32'sh0000_0000);   // head
        push_cmd(CMD_INSERT, 6'd63, 32'sh0000_0001);   // top position value
        push_cmd(CMD_INSERT, 6'd2,  32'shFFFF_FFFF);   // middle
        push_cmd(CMD_LOCATE, 6'd63, 32'sh7FFF_FFFF);   // hit at the tail
        push_cmd(CMD_LOCATE, 6'd0,  32'sh0000_0000);   // hit at the head
        push_cmd(CMD_LOCATE, 6'd5,  32'sh0001_E240);   // miss
        push_cmd(CMD_SPARE,  6'd63, 32'sh7FFF_FFFF);
        push_cmd(CMD_DELETE, 6'd0,  32'sh0000_0000);
        push_cmd(CMD_DELETE, 6'd5,  32'sh0000_0000);   // just past length
        push_cmd(CMD_DELETE, 6'd4,  32'sh0000_0000);   // tail
        push_cmd(CMD_DELETE, 6'd2,  32'sh0000_0000);   // middle
        push_cmd(CMD_INSERT, 6'd1,  32'shFFFF_FFFF);
        push_cmd(CMD_INSERT, 6'd1,  32'shFFFF_FFFF);
        push_cmd(CMD_LOCATE, 6'd0,  32'shFFFF_FFFF);   // first of duplicates
        push_cmd(CMD_DELETE, 6'd1,  32'sh0000_0000);
        push_cmd(CMD_DELETE, 6'd1,  32'sh0000_0000);
        push_cmd(CMD_DELETE, 6'd1,  32'sh0000_0000);
        push_cmd(CMD_DELETE, 6'd1,  32'sh0000_0000);   // back to empty
        push_cmd(CMD_LOCATE, 6'd0,  32'sh0000_0000);   // freed slots must not match
        wait_all_done();

        // Random phases. The first opens with a long result hold while the
        // sender keeps offering; each phase ends with the sender paused
        // until every result is back.
        sink_hold_left = HOLD_CYCLES;
        run_phase(0,  0,  PHASE_CMDS);
        run_phase(68, 0,  PHASE_CMDS);
        run_phase(0,  68, PHASE_CMDS);
        run_phase(18, 18, PHASE_CMDS);

        // quiet tail: anything arriving now is a result nobody asked for
        repeat (END_DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
